// ===== rtl/ckh_pkg.sv =====
// ----------------------------------------------------------------------------
// ckh_pkg: shared types and codes of the two-way cuckoo hash table
// Operation kinds, result status codes and the command and status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ckh_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LimitW  = 13;
  localparam int unsigned OccW    = 12;

  localparam logic [LimitW-1:0] KickLimitReset = 13'd1024;

  localparam logic [KindW-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 2'd1;
  localparam logic [KindW-1:0] KIND_REMOVE = 2'd2;

  localparam logic [StatusW-1:0] ST_HIT       = 3'd0;
  localparam logic [StatusW-1:0] ST_MISS      = 3'd1;
  localparam logic [StatusW-1:0] ST_INSERTED  = 3'd2;
  localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [StatusW-1:0] ST_REMOVED   = 3'd4;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 3'd5;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_LOAD   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_PLACE  = 3'd4,
    CMD_KICK   = 3'd5
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e              op;
    logic                 capture;
    logic [StatusW-1:0]   status;
  } ckh_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             hit;
    logic             cur_valid;
    logic             last_kick;
    logic             clear_last;
  } ckh_sts_t;

endpackage

// ===== rtl/ckh_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckh_ctrl: operation sequencer of the cuckoo hash table
// Runs the clearing pass, takes in operations, walks the kick chain and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module ckh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ckh_pkg::ckh_sts_t sts_i,
  output ckh_pkg::ckh_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_KICK  = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  ckh_pkg::cmd_op_e          step_op;
  logic                      step_cap;
  logic [ckh_pkg::StatusW-1:0] step_status;

  ckh_pkg::ckh_cmd_t cmd;
  ctrl_state_e       next_state;

  assign out_free = !out_valid_q || out_ready_i;

  // One link of the kick chain: place into a free slot or evict the occupant
  always_comb begin
    if (!sts_i.cur_valid) begin
      step_op     = ckh_pkg::CMD_PLACE;
      step_cap    = 1'b1;
      step_status = ckh_pkg::ST_INSERTED;
    end else begin
      step_op     = ckh_pkg::CMD_KICK;
      step_cap    = sts_i.last_kick;
      step_status = ckh_pkg::ST_OVERFLOW;
    end
  end

  always_comb begin
    cmd         = '{op: ckh_pkg::CMD_NONE, capture: 1'b0, status: ckh_pkg::ST_MISS};
    next_state  = state_q;
    in_ready_o  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd.op = ckh_pkg::CMD_CLEAR;
        if (sts_i.clear_last) begin
          next_state = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.op     = ckh_pkg::CMD_LOAD;
          next_state = S_LOOK;
        end
      end
      S_LOOK: begin
        next_state  = S_IDLE;
        cmd.capture = 1'b1;
        case (sts_i.kind)
          ckh_pkg::KIND_LOOKUP: begin
            cmd.status = sts_i.hit ? ckh_pkg::ST_HIT : ckh_pkg::ST_MISS;
          end
          ckh_pkg::KIND_REMOVE: begin
            if (sts_i.hit) begin
              cmd.op     = ckh_pkg::CMD_REMOVE;
              cmd.status = ckh_pkg::ST_REMOVED;
            end
          end
          ckh_pkg::KIND_INSERT: begin
            if (sts_i.hit) begin
              cmd.status = ckh_pkg::ST_DUPLICATE;
            end else begin
              cmd.op      = step_op;
              cmd.capture = step_cap;
              cmd.status  = step_status;
              next_state  = step_cap ? S_IDLE : S_KICK;
            end
          end
          default: begin
            cmd.status = ckh_pkg::ST_MISS;
          end
        endcase
      end
      S_KICK: begin
        cmd.op      = step_op;
        cmd.capture = step_cap;
        cmd.status  = step_status;
        next_state  = step_cap ? S_IDLE : S_KICK;
      end
      default: begin
        next_state = S_CLEAR;
      end
    endcase
  end

  // Hold a step that captures a result while the previous result still waits to be taken
  always_comb begin
    cmd_o   = cmd;
    state_d = next_state;
    if (cmd.capture && !out_free) begin
      cmd_o   = '{op: ckh_pkg::CMD_NONE, capture: 1'b0, status: ckh_pkg::ST_MISS};
      state_d = state_q;
    end
  end

  assign out_valid_d = cmd_o.capture || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/ckh_datapath.sv =====
// ----------------------------------------------------------------------------
// ckh_datapath: tables, held item and result register of the hash table
// Two single-port-write tables of {valid, key, value}, the item carried
// along the kick chain, the entry count and the kick limit register.
// ----------------------------------------------------------------------------
module ckh_datapath #(
  parameter int unsigned SLOTS_PER_TABLE = 1024,
  parameter int unsigned KEY_BITS        = 32,
  parameter int unsigned VALUE_BITS      = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ckh_pkg::LimitW-1:0]    cfg_data_i,
  input  logic [ckh_pkg::KindW-1:0]     kind_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [VALUE_BITS-1:0]         value_in_i,
  input  ckh_pkg::ckh_cmd_t             cmd_i,
  output ckh_pkg::ckh_sts_t             sts_o,
  output logic [ckh_pkg::StatusW-1:0]   status_o,
  output logic [VALUE_BITS-1:0]         value_out_o,
  output logic [KEY_BITS-1:0]           dropped_key_o,
  output logic [VALUE_BITS-1:0]         dropped_value_o,
  output logic [ckh_pkg::OccW-1:0]      occupancy_o
);

  // Slot index is a bit field of the key: tables must be a power of two deep
  localparam int unsigned IdxW = $clog2(SLOTS_PER_TABLE);
  localparam int unsigned ExtW = KEY_BITS + 2 * IdxW;
  localparam int unsigned EntW = 1 + KEY_BITS + VALUE_BITS;
  localparam int unsigned CntW = $clog2(2 * SLOTS_PER_TABLE + 1);
  localparam int unsigned LimW = ckh_pkg::LimitW;

  logic [EntW-1:0] mem0 [SLOTS_PER_TABLE];
  logic [EntW-1:0] mem1 [SLOTS_PER_TABLE];
  logic [EntW-1:0] rd0_q, rd1_q;

  logic                      rd0_en, rd1_en, wr0_en, wr1_en;
  logic [IdxW-1:0]           rd0_addr, rd1_addr, wr_addr;
  logic [EntW-1:0]           wr_data;

  logic [KEY_BITS-1:0]       held_key_q, held_key_d;
  logic [VALUE_BITS-1:0]     held_val_q, held_val_d;
  logic [ckh_pkg::KindW-1:0] kind_q;
  logic                      tab_q, tab_d;
  logic [LimW-1:0]           kicks_q, kicks_d;
  logic [LimW-1:0]           limit_q;
  logic [CntW-1:0]           count_q, count_d;
  logic [IdxW-1:0]           clr_q;

  logic [ExtW-1:0]           in_ext, held_ext, cur_ext;
  logic [IdxW-1:0]           in_s0, in_s1, held_s0, held_s1, cur_s1, cur_s0;
  logic                      hit0, hit1;
  logic [EntW-1:0]           cur;
  logic                      cur_valid;
  logic [KEY_BITS-1:0]       cur_key;
  logic [VALUE_BITS-1:0]     cur_val;
  logic [LimW-1:0]           eff_limit;
  logic [VALUE_BITS-1:0]     hit_val;

  assign in_ext   = {{(2 * IdxW){1'b0}}, key_i};
  assign held_ext = {{(2 * IdxW){1'b0}}, held_key_q};
  assign in_s1    = in_ext[IdxW-1:0];
  assign in_s0    = in_ext[2*IdxW-1:IdxW];
  assign held_s1  = held_ext[IdxW-1:0];
  assign held_s0  = held_ext[2*IdxW-1:IdxW];

  assign hit0 = rd0_q[EntW-1] && (rd0_q[KEY_BITS+VALUE_BITS-1:VALUE_BITS] == held_key_q);
  assign hit1 = rd1_q[EntW-1] && (rd1_q[KEY_BITS+VALUE_BITS-1:VALUE_BITS] == held_key_q);
  assign hit_val = hit0 ? rd0_q[VALUE_BITS-1:0] : rd1_q[VALUE_BITS-1:0];

  // Occupant of the slot that the held item targets in the current table
  assign cur       = tab_q ? rd1_q : rd0_q;
  assign cur_valid = cur[EntW-1];
  assign cur_key   = cur[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign cur_val   = cur[VALUE_BITS-1:0];
  assign cur_ext   = {{(2 * IdxW){1'b0}}, cur_key};
  assign cur_s1    = cur_ext[IdxW-1:0];
  assign cur_s0    = cur_ext[2*IdxW-1:IdxW];

  assign eff_limit = (limit_q == '0) ? LimW'(1) : limit_q;

  assign sts_o.kind       = kind_q;
  assign sts_o.hit        = hit0 || hit1;
  assign sts_o.cur_valid  = cur_valid;
  assign sts_o.last_kick  = ({1'b0, kicks_q} + {{LimW{1'b0}}, 1'b1}) >= {1'b0, eff_limit};
  assign sts_o.clear_last = (clr_q == IdxW'(SLOTS_PER_TABLE - 1));

  always_comb begin
    rd0_en     = 1'b0;
    rd1_en     = 1'b0;
    wr0_en     = 1'b0;
    wr1_en     = 1'b0;
    rd0_addr   = in_s0;
    rd1_addr   = in_s1;
    wr_addr    = tab_q ? held_s1 : held_s0;
    wr_data    = {1'b1, held_key_q, held_val_q};
    held_key_d = held_key_q;
    held_val_d = held_val_q;
    tab_d      = tab_q;
    kicks_d    = kicks_q;
    count_d    = count_q;
    case (cmd_i.op)
      ckh_pkg::CMD_CLEAR: begin
        wr0_en  = 1'b1;
        wr1_en  = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      ckh_pkg::CMD_LOAD: begin
        rd0_en     = 1'b1;
        rd1_en     = 1'b1;
        held_key_d = key_i;
        held_val_d = value_in_i;
        tab_d      = 1'b0;
        kicks_d    = '0;
      end
      ckh_pkg::CMD_REMOVE: begin
        // Clear the first matching entry, table 0 first
        wr0_en  = hit0;
        wr1_en  = !hit0;
        wr_addr = hit0 ? held_s0 : held_s1;
        wr_data = '0;
        count_d = count_q - CntW'(1);
      end
      ckh_pkg::CMD_PLACE: begin
        wr0_en  = !tab_q;
        wr1_en  = tab_q;
        count_d = count_q + CntW'(1);
      end
      ckh_pkg::CMD_KICK: begin
        // Evict the occupant and fetch its slot in the other table
        wr0_en     = !tab_q;
        wr1_en     = tab_q;
        rd0_en     = tab_q;
        rd1_en     = !tab_q;
        rd0_addr   = cur_s0;
        rd1_addr   = cur_s1;
        held_key_d = cur_key;
        held_val_d = cur_val;
        tab_d      = !tab_q;
        kicks_d    = kicks_q + LimW'(1);
      end
      default: begin
        wr_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr0_en) begin
      mem0[wr_addr] <= wr_data;
    end
    if (rd0_en) begin
      rd0_q <= mem0[rd0_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr1_en) begin
      mem1[wr_addr] <= wr_data;
    end
    if (rd1_en) begin
      rd1_q <= mem1[rd1_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    held_key_q <= held_key_d;
    held_val_q <= held_val_d;
    if (cmd_i.op == ckh_pkg::CMD_LOAD) begin
      kind_q <= kind_i;
    end
    if (cmd_i.capture) begin
      status_o        <= cmd_i.status;
      value_out_o     <= (cmd_i.status == ckh_pkg::ST_HIT) ? hit_val : '0;
      dropped_key_o   <= (cmd_i.status == ckh_pkg::ST_OVERFLOW) ? cur_key : '0;
      dropped_value_o <= (cmd_i.status == ckh_pkg::ST_OVERFLOW) ? cur_val : '0;
      occupancy_o     <= ckh_pkg::OccW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q   <= 1'b0;
      kicks_q <= '0;
      count_q <= '0;
      clr_q   <= '0;
      limit_q <= ckh_pkg::KickLimitReset;
    end else begin
      tab_q   <= tab_d;
      kicks_q <= kicks_d;
      count_q <= count_d;
      if (cmd_i.op == ckh_pkg::CMD_CLEAR) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== rtl/cuckoo_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// cuckoo_hash_table_top: two-way cuckoo hash map from keys to values
// Lookup, insert and remove on two tables indexed by bit fields of the key.
//
//   channel  direction  signals                                   payload
//   in       sink       in_valid_i / in_ready_o                   kind, key, value_in
//   out      source     out_valid_o / out_ready_i                 status, value_out,
//                                                                 dropped_key/value, occupancy
//   cfg      sink       cfg_valid_i / cfg_ready_o (always ready)  kick_limit
//
// Lookup, remove and duplicate insert: one table read per transaction.
// Insert adds one read of a table port for each kick (displacement),
// and on overflow the chain ends with the kick that drops an item.
// After reset a clearing pass over all SLOTS_PER_TABLE slots runs with in_ready_o low.
// A result waiting in the output register stalls only the step that produces the next.
// SLOTS_PER_TABLE must be a power of two.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_top #(
  parameter int unsigned SLOTS_PER_TABLE = 1024,
  parameter int unsigned KEY_BITS        = 32,
  parameter int unsigned VALUE_BITS      = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ckh_pkg::KindW-1:0]   kind_i,
  input  logic [KEY_BITS-1:0]         key_i,
  input  logic [VALUE_BITS-1:0]       value_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ckh_pkg::StatusW-1:0] status_o,
  output logic [VALUE_BITS-1:0]       value_out_o,
  output logic [KEY_BITS-1:0]         dropped_key_o,
  output logic [VALUE_BITS-1:0]       dropped_value_o,
  output logic [ckh_pkg::OccW-1:0]    occupancy_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ckh_pkg::LimitW-1:0]  cfg_data_i
);

  ckh_pkg::ckh_cmd_t cmd;
  ckh_pkg::ckh_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ckh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ckh_datapath #(
    .SLOTS_PER_TABLE (SLOTS_PER_TABLE),
    .KEY_BITS        (KEY_BITS),
    .VALUE_BITS      (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .value_in_i      (value_in_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (status_o),
    .value_out_o     (value_out_o),
    .dropped_key_o   (dropped_key_o),
    .dropped_value_o (dropped_value_o),
    .occupancy_o     (occupancy_o)
  );

  // One transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("input accepted while an operation is in flight");

  // A captured result is presented on the next cycle
  a_capture_shows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> out_valid_o
  ) else $error("captured result not presented");

  // Dropped item fields are zero unless the result reports an overflow
  a_drop_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ckh_pkg::ST_OVERFLOW) |->
      (dropped_key_o == '0) && (dropped_value_o == '0)
  ) else $error("dropped item reported without overflow");

  // No new operation is started during the clearing pass
  a_no_load_in_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == ckh_pkg::CMD_CLEAR) |-> !in_ready_o
  ) else $error("input ready during clearing pass");

endmodule
